// ===== rtl/plcfs_pkg.sv =====
// Package for the preemptive LCFS job stack: field widths, status and command
// codes, stack entry and result types. No dependencies.

package plcfs_pkg;

    localparam int DEF_STACK_DEPTH = 16;

    localparam int ID_W   = 16;
    localparam int TIME_W = 32;
    localparam int STAT_W = 2;

    // Input tdata: job_id, job_length, current_time (80 bits, 10 bytes)
    localparam int IN_DATA_W  = 80;
    // Output tdata: status, done_valid, done_id, cancel_pending, next_valid,
    // next_time (53 bits, padded to 56)
    localparam int OUT_DATA_W = 56;

    typedef enum logic {
        CMD_ARRIVE   = 1'b0,
        CMD_COMPLETE = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] rem;
    } t_entry;

    typedef struct packed {
        logic [TIME_W-1:0] next_time;
        logic              next_valid;
        logic              cancel_pending;
        logic [ID_W-1:0]   done_id;
        logic              done_valid;
        t_status           status;
    } t_result;

endpackage

// ===== rtl/preemptive_lcfs_job_stack_top.sv =====
// Preemptive LCFS job stack: running job held in registers, preempted jobs
// in a one-port synchronous stack memory. Depends on plcfs_pkg.
//
//   channel   dir   tdata                                         tuser
//   s_axis    in    job_id, job_length, current_time              command
//   m_axis    out   status, done_valid, done_id, cancel_pending,  -
//                   next_valid, next_time (zero pad to 56 bits)
//
// A transaction is taken in two steps: the accept cycle issues the stack read of
// the entry below the running job, and the execute state then updates state and loads
// the result register. The stack read is registered, which is why the execute state is needed.
// Reset empties the stack and clears start time; memory contents are left.
// A held result stalls the update cycle; input is taken again once it moves.

module preemptive_lcfs_job_stack_top #(
    parameter int STACK_DEPTH = plcfs_pkg::DEF_STACK_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // s_axis
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [15:0] job_id, [47:16] job_length, [79:48] current_time
    input  logic [plcfs_pkg::IN_DATA_W-1:0] i_s_tdata,
    // [0] command
    input  logic                            i_s_tuser,
    // m_axis
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [1:0] status, [2] done_valid, [18:3] done_id, [19] cancel_pending,
    // [20] next_valid, [52:21] next_time, [55:53] zero
    output logic [plcfs_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W  = $clog2(STACK_DEPTH);
    localparam int ID_W   = plcfs_pkg::ID_W;
    localparam int TIME_W = plcfs_pkg::TIME_W;
    localparam int RES_W  = $bits(plcfs_pkg::t_result);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [TIME_W-1:0]     r_start, n_start;
    logic [ID_W-1:0]       r_top_id, n_top_id;
    logic [TIME_W-1:0]     r_top_rem, n_top_rem;

    // latched transaction
    plcfs_pkg::t_cmd       r_cmd;
    logic [ID_W-1:0]       r_id;
    logic [TIME_W-1:0]     r_len;
    logic [TIME_W-1:0]     r_now;
    logic [TIME_W-1:0]     r_elapsed;

    plcfs_pkg::t_entry     r_stack [STACK_DEPTH];
    plcfs_pkg::t_entry     r_rdata;

    plcfs_pkg::t_result    r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic                  in_acc;
    logic                  out_free;
    logic                  exec_go;
    logic                  mem_we;
    plcfs_pkg::t_entry     wr_entry;
    logic [CNT_W-1:0]      cnt_m1;
    logic [CNT_W-1:0]      cnt_m2;
    logic [TIME_W:0]       charged;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign exec_go    = (r_state == S_EXEC) && out_free;

    assign cnt_m1  = r_count - CNT_W'(1);
    assign cnt_m2  = r_count - CNT_W'(2);
    assign charged = {1'b0, r_top_rem} - {1'b0, r_elapsed};

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(plcfs_pkg::OUT_DATA_W - RES_W)'(0), r_out};

    // Stack memory: write the preempted job, read the entry below the top
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[cnt_m1[IDX_W-1:0]] <= wr_entry;
        end
        if (in_acc) begin
            r_rdata <= r_stack[cnt_m2[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd     <= plcfs_pkg::t_cmd'(i_s_tuser);
            r_id      <= i_s_tdata[15:0];
            r_len     <= i_s_tdata[47:16];
            r_now     <= i_s_tdata[79:48];
            r_elapsed <= i_s_tdata[79:48] - r_start;
        end
        r_top_id  <= n_top_id;
        r_top_rem <= n_top_rem;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_start     = r_start;
        n_top_id    = r_top_id;
        n_top_rem   = r_top_rem;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        wr_entry.id  = r_top_id;
        wr_entry.rem = charged[TIME_W] ? '0 : charged[TIME_W-1:0];

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.status = plcfs_pkg::ST_OK;
                    if (r_cmd == plcfs_pkg::CMD_ARRIVE) begin
                        if (r_count >= CNT_W'(STACK_DEPTH)) begin
                            n_out.status = plcfs_pkg::ST_FULL;
                        end else begin
                            // push the charged running job below the newcomer
                            if (r_count != '0) begin
                                mem_we               = 1'b1;
                                n_out.cancel_pending = 1'b1;
                            end
                            n_top_id         = r_id;
                            n_top_rem        = r_len;
                            n_count          = r_count + CNT_W'(1);
                            n_start          = r_now;
                            n_out.next_valid = 1'b1;
                            n_out.next_time  = r_now + r_len;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_out.status = plcfs_pkg::ST_EMPTY;
                        end else begin
                            n_out.done_valid = 1'b1;
                            n_out.done_id    = r_top_id;
                            n_count          = cnt_m1;
                            n_start          = r_now;
                            // resume the entry read at accept
                            if (r_count > CNT_W'(1)) begin
                                n_top_id         = r_rdata.id;
                                n_top_rem        = r_rdata.rem;
                                n_out.next_valid = 1'b1;
                                n_out.next_time  = r_now + r_rdata.rem;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && r_cmd == plcfs_pkg::CMD_ARRIVE && r_count < CNT_W'(STACK_DEPTH))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("accepted arrival did not push");

    a_pop_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && r_cmd == plcfs_pkg::CMD_COMPLETE && r_count != '0)
        |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("completion did not pop");

    a_flags_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.done_valid || r_out.next_valid || r_out.cancel_pending))
        |-> (r_out.status == plcfs_pkg::ST_OK))
        else $error("result flags set on a rejected transaction");

    a_no_accept_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accepted transaction not executed");

endmodule

// ===== tb/lcfs_job_stack_monitor.sv =====
// Watches both stream channels of the LCFS job stack, predicts each result from
// the accepted events and compares it field by field. Depends on plcfs_pkg.
`timescale 1ns / 100ps

module lcfs_job_stack_monitor #(
    parameter int STACK_DEPTH = plcfs_pkg::DEF_STACK_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // [15:0] job_id, [47:16] job_length, [79:48] current_time
    input  logic [plcfs_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [0] command
    input  logic                             i_s_tuser,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // [1:0] status, [2] done_valid, [18:3] done_id, [19] cancel_pending,
    // [20] next_valid, [52:21] next_time, [55:53] zero
    input  logic [plcfs_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_events,
    output int                               o_done,
    output int                               o_preempt,
    output int                               o_saturate,
    output int                               o_full,
    output int                               o_empty
);

    import plcfs_pkg::*;

    localparam int RES_W      = $bits(t_result);

    logic [ID_W-1:0]   job_ids [STACK_DEPTH];
    logic [TIME_W-1:0] job_rem [STACK_DEPTH];
    int                depth_used   = 0;
    logic [TIME_W-1:0] run_start    = '0;
    t_result           expected_results [$];
    int                results_seen = 0;

    int n_fail = 0, n_events = 0, n_done = 0, n_preempt = 0;
    int n_saturate = 0, n_full = 0, n_empty = 0;

    assign o_fail_count = n_fail;
    assign o_events     = n_events;
    assign o_done       = n_done;
    assign o_preempt    = n_preempt;
    assign o_saturate   = n_saturate;
    assign o_full       = n_full;
    assign o_empty      = n_empty;

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        n_fail++;
        $display("%0t: result %0d: %s expected %0h, got %0h",
                 $realtime, results_seen, field, want, got);
    endtask

    // Advance the job stack by one event and return the result it produces.
    function automatic t_result schedule_event(input t_cmd cmd, input logic [ID_W-1:0] id,
                                               input logic [TIME_W-1:0] len,
                                               input logic [TIME_W-1:0] now);
        t_result           res;
        logic [TIME_W-1:0] elapsed;
        res        = '0;
        res.status = ST_OK;
        if (cmd == CMD_ARRIVE) begin
            if (depth_used >= STACK_DEPTH) begin
                res.status = ST_FULL;
                n_full++;
            end else begin
                if (depth_used > 0) begin
                    // charge the preempted job, never below zero
                    elapsed = now - run_start;
                    if (job_rem[depth_used-1] > elapsed) begin
                        job_rem[depth_used-1] = job_rem[depth_used-1] - elapsed;
                    end else begin
                        job_rem[depth_used-1] = '0;
                        n_saturate++;
                    end
                    res.cancel_pending = 1'b1;
                    n_preempt++;
                end
                job_ids[depth_used] = id;
                job_rem[depth_used] = len;
                depth_used++;
                run_start      = now;
                res.next_valid = 1'b1;
                res.next_time  = now + len;
            end
        end else begin
            if (depth_used == 0) begin
                res.status = ST_EMPTY;
                n_empty++;
            end else begin
                depth_used--;
                res.done_valid = 1'b1;
                res.done_id    = job_ids[depth_used];
                run_start      = now;
                n_done++;
                if (depth_used > 0) begin
                    res.next_valid = 1'b1;
                    res.next_time  = now + job_rem[depth_used-1];
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            depth_used = 0;
            run_start  = '0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[RES_W-1:0]);
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none expected", '0, i_m_tdata[31:0]);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(got.status));
                    if (got.done_valid !== want.done_valid)
                        report_mismatch("done_valid", 32'(want.done_valid),
                                        32'(got.done_valid));
                    if (got.done_id !== want.done_id)
                        report_mismatch("done_id", 32'(want.done_id), 32'(got.done_id));
                    if (got.cancel_pending !== want.cancel_pending)
                        report_mismatch("cancel_pending", 32'(want.cancel_pending),
                                        32'(got.cancel_pending));
                    if (got.next_valid !== want.next_valid)
                        report_mismatch("next_valid", 32'(want.next_valid),
                                        32'(got.next_valid));
                    if (got.next_time !== want.next_time)
                        report_mismatch("next_time", want.next_time, got.next_time);
                    if (i_m_tdata[OUT_DATA_W-1:RES_W] !== '0)
                        report_mismatch("padding", '0,
                                        32'(i_m_tdata[OUT_DATA_W-1:RES_W]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                n_events++;
                expected_results.push_back(schedule_event(t_cmd'(i_s_tuser),
                                                          i_s_tdata[15:0],
                                                          i_s_tdata[47:16],
                                                          i_s_tdata[79:48]));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/tb_preemptive_lcfs_job_stack_top.sv =====
// Testbench top for preemptive_lcfs_job_stack_top: clock, reset, event stimulus
// and result back-pressure, verdict. Depends on plcfs_pkg and lcfs_job_stack_monitor.
`timescale 1ns / 100ps

module tb_preemptive_lcfs_job_stack_top;

    import plcfs_pkg::*;

    localparam int RANDOM_EVENTS  = 450;
    localparam int QUIET_TAIL     = 60;
    localparam int DRAIN_CYCLES   = 8;
    // slowest legal gap between transactions: idle time on the send side, stalls on
    // the receive side and the work of one transaction; take it many times over
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    int fail_count, pending, events, done, preempt, saturate, full, empty;
    int stall_cycles;
    bit gaps_on;

    preemptive_lcfs_job_stack_top #(
        .STACK_DEPTH (DEF_STACK_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    lcfs_job_stack_monitor #(
        .STACK_DEPTH (DEF_STACK_DEPTH)
    ) u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_events     (events),
        .o_done       (done),
        .o_preempt    (preempt),
        .o_saturate   (saturate),
        .o_full       (full),
        .o_empty      (empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Present one event at a falling edge and hold it until the block takes it.
    task automatic send_event(input t_cmd cmd, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] len,
                              input logic [TIME_W-1:0] now);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {now, len, id};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // Result back-pressure: random stalls, none once the tail starts.
    initial begin
        m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (gaps_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int                i;
        int                mode;
        int                burst_left;
        int                pick;
        int                arrive_pct;
        t_cmd              cmd;
        logic [TIME_W-1:0] sim_now;
        logic [TIME_W-1:0] len;
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        gaps_on      = 1'b1;
        burst_left   = 0;
        mode         = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty stack, last job leaving, wrap of times, saturation, full stack
        send_event(CMD_COMPLETE, 16'h0000, 32'h0000_0000, 32'd5);
        send_event(CMD_ARRIVE,   16'h0000, 32'h0000_0000, 32'd0);
        send_event(CMD_COMPLETE, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        send_event(CMD_ARRIVE,   16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(CMD_ARRIVE,   16'h0001, 32'd10,        32'd5);
        send_event(CMD_ARRIVE,   16'h0002, 32'd3,         32'd100);
        send_event(CMD_COMPLETE, 16'h0000, 32'h0000_0000, 32'd200);
        for (i = 0; i < 14; i++)
            send_event(CMD_ARRIVE, 16'h0100 + i[15:0],
                       i[0] ? 32'hFFFF_FFF0 : i[31:0] * 7, 32'd300 + i[31:0] * 11);
        send_event(CMD_ARRIVE,   16'hAAAA, 32'h5555_5555, 32'd500);
        send_event(CMD_COMPLETE, 16'h5555, 32'hAAAA_AAAA, 32'd510);
        send_event(CMD_COMPLETE, 16'h0000, 32'h0000_0000, 32'd520);

        // random: bursts that lean towards filling or draining the stack
        sim_now = 32'd600;
        for (i = 0; i < RANDOM_EVENTS; i++) begin
            if (i == RANDOM_EVENTS - QUIET_TAIL)
                gaps_on = 1'b0;
            if (burst_left == 0) begin
                mode       = $urandom_range(0, 2);
                burst_left = $urandom_range(8, 40);
            end
            burst_left--;
            arrive_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            cmd = ($urandom_range(0, 99) < arrive_pct) ? CMD_ARRIVE : CMD_COMPLETE;

            pick = $urandom_range(0, 19);
            if (pick == 0)
                sim_now = $urandom;
            else if (pick == 1)
                sim_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
            else
                sim_now = sim_now + $urandom_range(0, 60);

            pick = $urandom_range(0, 9);
            if (pick == 0)
                len = '0;
            else if (pick <= 2)
                len = $urandom;
            else
                len = $urandom_range(1, 120);

            send_event(cmd, 16'($urandom), len, sim_now);
        end
        s_tvalid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d events: %0d completed, %0d preemptions, %0d clamped charges",
                 events, done, preempt, saturate);
        $display("  %0d arrivals dropped on a full stack, %0d completions on an empty stack",
                 full, empty);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/plcfs_pkg.sv
rtl/preemptive_lcfs_job_stack_top.sv
tb/lcfs_job_stack_monitor.sv
tb/tb_preemptive_lcfs_job_stack_top.sv
